// ----- rtl/hpid_pkg.sv -----
package hpid_pkg;

    localparam int HPID_WINDOW_DEPTH = 32;

    localparam int ADC_W     = 10;
    localparam int TEMP_W    = 10;
    localparam int DRIVE_W   = 10;
    localparam int TARGET_W  = 9;
    localparam int GAIN_W    = 7;
    localparam int OFFSET_W  = 8;
    localparam int INTEG_W   = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // Signed working widths of the control arithmetic.
    localparam int ERR_W    = 12;
    localparam int SUM_W    = 26;
    localparam int MUL_W    = 22;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SCALED_W = 19;

    // Scaling raw*430/643: the division by 643 is a multiplication by
    // ceil(2^29/643) followed by a 29-bit shift, exact for 19-bit dividends.
    localparam int SLOPE_NUM    = 430;
    localparam int RECIP_MUL    = 834947;
    localparam int RECIP_SHIFT  = 29;
    localparam int TEMP_LIMIT   = 999;
    localparam int CUTOFF_TEMP  = 500;
    localparam int DRIVE_MAX    = 1023;
    localparam int INTEG_MAX    = 80000;
    localparam int INTEG_SHIFT  = 11;

    localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(300);
    localparam logic [GAIN_W-1:0]   PROP_RESET   = GAIN_W'(22);
    localparam logic [GAIN_W-1:0]   INTEG_RESET  = GAIN_W'(17);
    localparam logic [GAIN_W-1:0]   DERIV_RESET  = GAIN_W'(0);
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(38);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_TEMP = 3'd0,
        REG_PROP_GAIN   = 3'd1,
        REG_INTEG_GAIN  = 3'd2,
        REG_DERIV_GAIN  = 3'd3,
        REG_TEMP_OFFSET = 3'd4
    } hpid_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_RECIP,
        ST_CONV,
        ST_PROP,
        ST_INTEG,
        ST_DERIV,
        ST_SUM,
        ST_REINTEG,
        ST_RESUM,
        ST_OUT
    } hpid_state_t;

endpackage

// ----- rtl/hpid_ram.sv -----
module hpid_ram
    import hpid_pkg::*;
#(
    parameter int WIDTH = TEMP_W,
    parameter int DEPTH = HPID_WINDOW_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/heater_pid_controller.sv -----
// Heater PID controller.
// Each word on the s_ channel carries one averaged thermocouple reading; for
// every accepted word exactly one word leaves on the m_ channel with the
// heater duty, the converted temperature and the over-temperature flag.
// Gains, setpoint and offset are written through the cfg_ channel; the user
// must write them only while the block is idle, which the block does not
// enforce. cfg_ready is always high and unknown indexes are ignored.
// One item is worked on at a time. A single shared multiplier runs the
// scaling, reciprocal division and P, I and D products in turn. A PID step
// passes scale, reciprocal, conversion, P, I, D and sum; the anti-windup path
// updates the integral, then redoes the I product and sum for the output.
// The first sample after reset and samples at or above the cutoff go from
// conversion straight to output; s_tready rises again as m_tvalid rises.
// The sample history sits in a RAM of WINDOW_DEPTH entries; entries not yet
// written since priming read as the priming temperature.
// Reset clears the configuration to its defaults and unprimes the loop.
// A result waits in the output register while m_tready is low; the next
// sample is still accepted and processed, and it is held back only when its
// own result is ready before the previous one has been taken.
module heater_pid_controller
    import hpid_pkg::*;
#(
    parameter int WINDOW_DEPTH = HPID_WINDOW_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] adc_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [9:0] heater_drive, [19:10] measured_temp
    output logic                  m_tuser,   // [0] over_temp

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DAT_W-1:0]  cfg_wdata
);

    localparam int POS_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

    hpid_state_t state_reg, state_next;

    logic [TARGET_W-1:0] target_reg;
    logic [GAIN_W-1:0]   kp_reg, ki_reg, kd_reg;
    logic [OFFSET_W-1:0] offset_reg;

    logic [ADC_W-1:0]    raw_reg;
    logic [TEMP_W-1:0]   temp_reg;
    logic                hot_reg;
    logic signed [ERR_W-1:0]  err_reg, dtemp_reg;
    logic signed [SUM_W-1:0]  pd_reg, i_reg, drive_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [MUL_W-1:0]  mul_a, mul_b;

    logic [INTEG_W-1:0]  integ_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [FILL_W-1:0]   filled_reg;
    logic [TEMP_W-1:0]   prime_reg;
    logic                primed_reg;

    logic                m_tvalid_reg;
    logic [DRIVE_W-1:0]  drive_out_reg;
    logic [TEMP_W-1:0]   temp_out_reg;
    logic                hot_out_reg;

    logic [TEMP_W-1:0]   hist_rdata;
    logic                hist_we;

    logic                s_accept, out_free;
    logic [TEMP_W:0]     temp_sum;
    logic [TEMP_W-1:0]   temp_conv;
    logic signed [PROD_W-1:0] prod_shr;
    logic signed [SUM_W-1:0]  pd_sum, drive_sum;
    logic                in_band;
    logic signed [INTEG_W+1:0] integ_sum;
    logic [INTEG_W-1:0]  integ_clamped;
    logic [TEMP_W-1:0]   old_temp;
    logic [DRIVE_W-1:0]  drive_clamped;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - DRIVE_W - TEMP_W){1'b0}}, temp_out_reg, drive_out_reg};
    assign m_tuser  = hot_out_reg;

    assign temp_sum  = {1'b0, prod_reg[RECIP_SHIFT+TEMP_W-1:RECIP_SHIFT]}
                     + (TEMP_W+1)'(offset_reg);
    assign temp_conv = (temp_sum > (TEMP_W+1)'(TEMP_LIMIT)) ? TEMP_W'(TEMP_LIMIT)
                                                            : temp_sum[TEMP_W-1:0];

    assign prod_shr  = prod_reg >>> INTEG_SHIFT;
    assign pd_sum    = pd_reg - SUM_W'(prod_reg);
    assign drive_sum = pd_sum + i_reg;
    assign in_band   = (drive_sum > 0) && (drive_sum < DRIVE_MAX);

    assign integ_sum = $signed({2'b00, integ_reg}) + (INTEG_W+2)'(err_reg);
    always_comb begin
        if (integ_sum < 0) begin
            integ_clamped = '0;
        end else if (integ_sum > INTEG_MAX) begin
            integ_clamped = INTEG_W'(INTEG_MAX);
        end else begin
            integ_clamped = integ_sum[INTEG_W-1:0];
        end
    end

    assign old_temp = (filled_reg < FILL_W'(WINDOW_DEPTH)) ? prime_reg : hist_rdata;

    always_comb begin
        if (drive_reg < 0) begin
            drive_clamped = '0;
        end else if (drive_reg > DRIVE_MAX) begin
            drive_clamped = DRIVE_W'(DRIVE_MAX);
        end else begin
            drive_clamped = drive_reg[DRIVE_W-1:0];
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SCALE: begin
                mul_a = $signed({{(MUL_W-ADC_W){1'b0}}, raw_reg});
                mul_b = MUL_W'(SLOPE_NUM);
            end
            ST_RECIP: begin
                mul_a = $signed({{(MUL_W-SCALED_W){1'b0}}, prod_reg[SCALED_W-1:0]});
                mul_b = MUL_W'(RECIP_MUL);
            end
            ST_PROP: begin
                mul_a = MUL_W'(err_reg);
                mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, kp_reg});
            end
            ST_INTEG, ST_REINTEG: begin
                mul_a = $signed({{(MUL_W-INTEG_W){1'b0}}, integ_reg});
                mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, ki_reg});
            end
            ST_DERIV: begin
                mul_a = MUL_W'(dtemp_reg);
                mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, kd_reg});
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        hist_we    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:   state_next = ST_RECIP;
            ST_RECIP:   state_next = ST_CONV;
            ST_CONV: begin
                if (!primed_reg || temp_conv >= TEMP_W'(CUTOFF_TEMP)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PROP;
                end
            end
            ST_PROP: begin
                hist_we    = 1'b1;
                state_next = ST_INTEG;
            end
            ST_INTEG:   state_next = ST_DERIV;
            ST_DERIV:   state_next = ST_SUM;
            ST_SUM:     state_next = in_band ? ST_REINTEG : ST_OUT;
            ST_REINTEG: state_next = ST_RESUM;
            ST_RESUM:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TARGET_RESET;
            kp_reg     <= PROP_RESET;
            ki_reg     <= INTEG_RESET;
            kd_reg     <= DERIV_RESET;
            offset_reg <= OFFSET_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_TARGET_TEMP: target_reg <= cfg_wdata[TARGET_W-1:0];
                REG_PROP_GAIN:   kp_reg     <= cfg_wdata[GAIN_W-1:0];
                REG_INTEG_GAIN:  ki_reg     <= cfg_wdata[GAIN_W-1:0];
                REG_DERIV_GAIN:  kd_reg     <= cfg_wdata[GAIN_W-1:0];
                REG_TEMP_OFFSET: offset_reg <= cfg_wdata[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (s_accept) begin
            raw_reg <= s_tdata[ADC_W-1:0];
        end
        unique case (state_reg)
            ST_CONV: begin
                temp_reg  <= temp_conv;
                hot_reg   <= (temp_conv >= TEMP_W'(CUTOFF_TEMP));
                err_reg   <= $signed({{(ERR_W-TARGET_W){1'b0}}, target_reg})
                           - $signed({{(ERR_W-TEMP_W){1'b0}}, temp_conv});
                drive_reg <= '0;
            end
            ST_PROP: begin
                dtemp_reg <= $signed({{(ERR_W-TEMP_W){1'b0}}, temp_reg})
                           - $signed({{(ERR_W-TEMP_W){1'b0}}, old_temp});
            end
            ST_INTEG:  pd_reg <= SUM_W'(prod_reg);
            ST_DERIV:  i_reg  <= SUM_W'(prod_shr);
            ST_SUM: begin
                pd_reg    <= pd_sum;
                drive_reg <= drive_sum;
            end
            ST_RESUM:  drive_reg <= pd_reg + SUM_W'(prod_shr);
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg  <= '0;
            pos_reg    <= '0;
            filled_reg <= '0;
            prime_reg  <= '0;
            primed_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_CONV: begin
                    if (!primed_reg) begin
                        prime_reg  <= temp_conv;
                        integ_reg  <= '0;
                        pos_reg    <= '0;
                        filled_reg <= '0;
                        primed_reg <= 1'b1;
                    end
                end
                ST_PROP: begin
                    if (filled_reg < FILL_W'(WINDOW_DEPTH)) begin
                        filled_reg <= filled_reg + 1'b1;
                    end
                    if (pos_reg == POS_W'(WINDOW_DEPTH - 1)) begin
                        pos_reg <= '0;
                    end else begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                ST_SUM: begin
                    if (in_band) begin
                        integ_reg <= integ_clamped;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            drive_out_reg <= drive_clamped;
            temp_out_reg  <= temp_reg;
            hot_out_reg   <= hot_reg;
        end
    end

    hpid_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (pos_reg),
        .wdata (temp_reg),
        .raddr (pos_reg),
        .rdata (hist_rdata)
    );

endmodule
